/* src/tsalu_pkg.sv */
// shared constants, command codes and result type for the time value alu
package tsalu_pkg;

    localparam int unsigned SEC_W = 32;
    localparam int unsigned NSEC_W = 32;

    localparam logic [NSEC_W-1:0] NS_PER_SEC = 32'd1000000000;
    localparam logic [SEC_W-1:0] SEC_MAX = 32'hFFFF_FFFF;

    // command codes
    typedef enum logic [1:0] {
        CMD_NORM = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_CMP  = 2'd3
    } cmd_t;

    // one result word
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
        logic              is_equal;
        logic              is_greater;
        logic              is_less;
    } res_t;

endpackage

/* src/tsalu_norm.sv */
// normalize unit: folds whole billions of nanoseconds into seconds with saturation
module tsalu_norm (
    input  logic [tsalu_pkg::SEC_W-1:0]  sec_in,
    input  logic [tsalu_pkg::NSEC_W-1:0] nsec_in,
    output logic [tsalu_pkg::SEC_W-1:0]  sec_out,
    output logic [tsalu_pkg::NSEC_W-1:0] nsec_out
);
    import tsalu_pkg::*;

    logic [2:0]        carry_cnt;
    logic [NSEC_W-1:0] nsec_rem;
    logic [SEC_W:0]    sec_sum;

    // a 32-bit count holds at most four whole billions
    always_comb
    begin
        priority if (nsec_in >= 32'd4000000000)
        begin
            carry_cnt = 3'd4;
            nsec_rem  = nsec_in - 32'd4000000000;
        end
        else if (nsec_in >= 32'd3000000000)
        begin
            carry_cnt = 3'd3;
            nsec_rem  = nsec_in - 32'd3000000000;
        end
        else if (nsec_in >= 32'd2000000000)
        begin
            carry_cnt = 3'd2;
            nsec_rem  = nsec_in - 32'd2000000000;
        end
        else if (nsec_in >= NS_PER_SEC)
        begin
            carry_cnt = 3'd1;
            nsec_rem  = nsec_in - NS_PER_SEC;
        end
        else
        begin
            carry_cnt = 3'd0;
            nsec_rem  = nsec_in;
        end
    end

    // seconds plus carries, saturate when the count passes the maximum
    assign sec_sum = {1'b0, sec_in} + {{(SEC_W-2){1'b0}}, carry_cnt};

    always_comb
    begin
        if (sec_sum[SEC_W])
        begin
            sec_out  = SEC_MAX;
            nsec_out = NS_PER_SEC;
        end
        else
        begin
            sec_out  = sec_sum[SEC_W-1:0];
            nsec_out = nsec_rem;
        end
    end

endmodule

/* src/tsalu_datapath.sv */
// combinational datapath: normalize, add, subtract and compare of one word
module tsalu_datapath (
    input  tsalu_pkg::cmd_t               cmd,
    input  logic [tsalu_pkg::SEC_W-1:0]   a_sec,
    input  logic [tsalu_pkg::NSEC_W-1:0]  a_nsec,
    input  logic [tsalu_pkg::SEC_W-1:0]   b_sec,
    input  logic [tsalu_pkg::NSEC_W-1:0]  b_nsec,
    output tsalu_pkg::res_t               res
);
    import tsalu_pkg::*;

    logic [SEC_W:0]    add_sec;
    logic [NSEC_W-1:0] add_nsec;
    logic [SEC_W-1:0]  norm_sec_in;
    logic [NSEC_W-1:0] norm_nsec_in;
    logic [SEC_W-1:0]  norm_sec;
    logic [NSEC_W-1:0] norm_nsec;
    logic [SEC_W-1:0]  sub_sec;
    logic [NSEC_W-1:0] sub_nsec;
    logic [SEC_W-1:0]  sec_diff;
    logic              sec_eq;
    logic              sec_gt;
    logic              sec_lt;
    logic              nsec_lt;

    // wrapping nanosecond sum, seconds sum with carry out
    assign add_sec  = {1'b0, a_sec} + {1'b0, b_sec};
    assign add_nsec = a_nsec + b_nsec;

    // shared normalize unit; the carry of an add is one normalize step
    assign norm_sec_in  = (cmd == CMD_ADD) ? add_sec[SEC_W-1:0] : a_sec;
    assign norm_nsec_in = (cmd == CMD_ADD) ? add_nsec : a_nsec;

    tsalu_norm u_norm (
        .sec_in   (norm_sec_in),
        .nsec_in  (norm_nsec_in),
        .sec_out  (norm_sec),
        .nsec_out (norm_nsec)
    );

    // field compares
    assign sec_eq  = (a_sec == b_sec);
    assign sec_gt  = (a_sec > b_sec);
    assign sec_lt  = (a_sec < b_sec);
    assign nsec_lt = (a_nsec < b_nsec);

    // subtract with borrow, clamp to zero on underrun
    assign sec_diff = a_sec - b_sec;

    always_comb
    begin
        if (sec_lt)
        begin
            sub_sec  = '0;
            sub_nsec = '0;
        end
        else if (nsec_lt)
        begin
            if (sec_eq)
            begin
                sub_sec  = '0;
                sub_nsec = '0;
            end
            else
            begin
                sub_sec  = sec_diff - 32'd1;
                sub_nsec = NS_PER_SEC + a_nsec - b_nsec;
            end
        end
        else
        begin
            sub_sec  = sec_diff;
            sub_nsec = a_nsec - b_nsec;
        end
    end

    // result select and flags
    always_comb
    begin
        res.is_equal   = sec_eq && (a_nsec == b_nsec);
        res.is_greater = sec_gt || (sec_eq && (a_nsec > b_nsec));
        res.is_less    = sec_lt || (sec_eq && nsec_lt);
        unique case (cmd)
            CMD_NORM:
            begin
                res.sec  = norm_sec;
                res.nsec = norm_nsec;
            end
            CMD_ADD:
            begin
                if (add_sec[SEC_W])
                begin
                    res.sec  = SEC_MAX;
                    res.nsec = NS_PER_SEC;
                end
                else
                begin
                    res.sec  = norm_sec;
                    res.nsec = norm_nsec;
                end
            end
            CMD_SUB:
            begin
                res.sec  = sub_sec;
                res.nsec = sub_nsec;
            end
            default:
            begin
                res.sec  = '0;
                res.nsec = '0;
            end
        endcase
    end

endmodule

/* src/saturating_time_value_alu.sv */
// top level of the saturating time value alu: input and result registers
//
// Usage:
//   Command channel: drive command, a_sec, a_nsec, b_sec and b_nsec and
//   raise start; the word is taken at a rising edge where start is high and
//   busy is low. busy stays low, so a new word may be issued every cycle.
//   Result channel: done is high for exactly one cycle while res_sec,
//   res_nsec, is_equal, is_greater and is_less hold the result. There is
//   no backpressure; the receiver must take the word in that cycle.
//   Path: a word taken by start is captured in the input register, goes
//   through the datapath, and is loaded into the result register; done is
//   raised by the same edge that loads the result register.
//   Throughput: one word per cycle, set by the single pass from the input
//   register through the normalize unit to the result register.
//   Reset: rst_n low clears both valid flags at once; no word in flight
//   survives and done is low until a new word has passed through.
module saturating_time_value_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     command,
    input  logic [tsalu_pkg::SEC_W-1:0]    a_sec,
    input  logic [tsalu_pkg::NSEC_W-1:0]   a_nsec,
    input  logic [tsalu_pkg::SEC_W-1:0]    b_sec,
    input  logic [tsalu_pkg::NSEC_W-1:0]   b_nsec,
    output logic                           done,
    output logic [tsalu_pkg::SEC_W-1:0]    res_sec,
    output logic [tsalu_pkg::NSEC_W-1:0]   res_nsec,
    output logic                           is_equal,
    output logic                           is_greater,
    output logic                           is_less
);
    import tsalu_pkg::*;

    logic              in_valid_reg;
    cmd_t              cmd_reg;
    logic [SEC_W-1:0]  a_sec_reg;
    logic [NSEC_W-1:0] a_nsec_reg;
    logic [SEC_W-1:0]  b_sec_reg;
    logic [NSEC_W-1:0] b_nsec_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              accept;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            a_sec_reg  <= a_sec;
            a_nsec_reg <= a_nsec;
            b_sec_reg  <= b_sec;
            b_nsec_reg <= b_nsec;
        end
    end

    tsalu_datapath u_datapath (
        .cmd    (cmd_reg),
        .a_sec  (a_sec_reg),
        .a_nsec (a_nsec_reg),
        .b_sec  (b_sec_reg),
        .b_nsec (b_nsec_reg),
        .res    (res_next)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // result word outputs
    assign done       = out_valid_reg;
    assign res_sec    = res_reg.sec;
    assign res_nsec   = res_reg.nsec;
    assign is_equal   = res_reg.is_equal;
    assign is_greater = res_reg.is_greater;
    assign is_less    = res_reg.is_less;

endmodule

/* tb/tb.sv */
// self-checking testbench for the saturating time value alu
`timescale 1ns / 1ps

module tb;

    import tsalu_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1750;
    localparam logic [31:0] NSEC_LAST = 32'd999999999;

    // one command word as it goes to the block
    typedef struct packed {
        cmd_t        command;
        logic [31:0] a_sec;
        logic [31:0] a_nsec;
        logic [31:0] b_sec;
        logic [31:0] b_nsec;
    } time_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = CMD_NORM;
    logic [31:0] a_sec = '0;
    logic [31:0] a_nsec = '0;
    logic [31:0] b_sec = '0;
    logic [31:0] b_nsec = '0;
    logic        done;
    logic [31:0] res_sec;
    logic [31:0] res_nsec;
    logic        is_equal;
    logic        is_greater;
    logic        is_less;

    time_word_t  command_words[$];
    res_t        predicted_results[$];
    time_word_t  in_flight;
    int unsigned words_issued = 0;
    int unsigned total_words = 0;
    int unsigned error_count = 0;
    bit          all_sent = 1'b0;

    saturating_time_value_alu dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .a_sec      (a_sec),
        .a_nsec     (a_nsec),
        .b_sec      (b_sec),
        .b_nsec     (b_nsec),
        .done       (done),
        .res_sec    (res_sec),
        .res_nsec   (res_nsec),
        .is_equal   (is_equal),
        .is_greater (is_greater),
        .is_less    (is_less)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // carry whole billions of nanoseconds into seconds, sticking at the top
    function automatic logic [63:0] normalize_time(logic [31:0] sec, logic [31:0] nsec);
        bit stop;
        stop = 1'b0;
        for (int step = 0; step < 5; step++)
        begin
            if (!stop && nsec >= NS_PER_SEC)
            begin
                if (sec != SEC_MAX)
                begin
                    sec = sec + 32'd1;
                    nsec = nsec - NS_PER_SEC;
                end
                else
                begin
                    nsec = NS_PER_SEC;
                    stop = 1'b1;
                end
            end
        end
        return {sec, nsec};
    endfunction

    // expected result word for one command word
    function automatic res_t predict_time_result(time_word_t w);
        logic [31:0] rs;
        logic [31:0] rn;
        res_t        r;
        rs = '0;
        rn = '0;
        case (w.command)
            CMD_NORM:
            begin
                {rs, rn} = normalize_time(w.a_sec, w.a_nsec);
            end
            CMD_ADD:
            begin
                if ((SEC_MAX - w.a_sec) < w.b_sec)
                begin
                    rs = SEC_MAX;
                    rn = NS_PER_SEC;
                end
                else
                begin
                    rs = w.a_sec + w.b_sec;
                    rn = w.a_nsec + w.b_nsec;
                    if (rn >= NS_PER_SEC)
                    begin
                        if (rs == SEC_MAX)
                            rn = NS_PER_SEC;
                        else
                        begin
                            rn = rn - NS_PER_SEC;
                            rs = rs + 32'd1;
                        end
                    end
                end
                {rs, rn} = normalize_time(rs, rn);
            end
            CMD_SUB:
            begin
                if (w.a_sec < w.b_sec)
                begin
                    rs = '0;
                    rn = '0;
                end
                else
                begin
                    rs = w.a_sec - w.b_sec;
                    if (w.a_nsec < w.b_nsec)
                    begin
                        if (rs == 32'd0)
                            rn = '0;
                        else
                        begin
                            rn = NS_PER_SEC - (w.b_nsec - w.a_nsec);
                            rs = rs - 32'd1;
                        end
                    end
                    else
                        rn = w.a_nsec - w.b_nsec;
                end
            end
            default:
            begin
                rs = '0;
                rn = '0;
            end
        endcase
        r.sec = rs;
        r.nsec = rn;
        r.is_equal = (w.a_sec == w.b_sec) && (w.a_nsec == w.b_nsec);
        r.is_greater = (w.a_sec > w.b_sec) || ((w.a_sec == w.b_sec) && (w.a_nsec > w.b_nsec));
        r.is_less = (w.a_sec < w.b_sec) || ((w.a_sec == w.b_sec) && (w.a_nsec < w.b_nsec));
        return r;
    endfunction

    task automatic queue_word(cmd_t c, logic [31:0] as, logic [31:0] an,
                              logic [31:0] bs, logic [31:0] bn);
        time_word_t w;
        w.command = c;
        w.a_sec = as;
        w.a_nsec = an;
        w.b_sec = bs;
        w.b_nsec = bn;
        command_words.push_back(w);
    endtask

    // seconds biased toward zero, the top and the middle
    function automatic logic [31:0] pick_sec();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 3);
            1:       return SEC_MAX - $urandom_range(0, 3);
            2:       return 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
            default: return $urandom;
        endcase
    endfunction

    // nanoseconds biased toward the billion boundaries and the extremes
    function automatic logic [31:0] pick_nsec();
        case ($urandom_range(0, 6))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(0, NSEC_LAST);
            2:       return NS_PER_SEC + $urandom_range(0, 4) - 32'd2;
            3:       return NS_PER_SEC * $urandom_range(1, 4) + $urandom_range(0, 4) - 32'd2;
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // driver: one word per accepted start, with random gaps by phase
    always @(posedge clk)
    begin : drive_words
        int unsigned idle_pct;
        time_word_t  nxt;
        bit          next_start;
        if (rst_n)
        begin
            if (start && !busy)
                predicted_results.push_back(predict_time_result(in_flight));
            if (!start || !busy)
            begin
                if (words_issued < total_words / 3)
                    idle_pct = 14;
                else if (words_issued < (2 * total_words) / 3)
                    idle_pct = 60;
                else
                    idle_pct = 0;
                next_start = (command_words.size() > 0) && ($urandom_range(0, 99) >= idle_pct);
                if (next_start)
                begin
                    nxt = command_words.pop_front();
                    in_flight = nxt;
                    words_issued++;
                    command <= nxt.command;
                    a_sec <= nxt.a_sec;
                    a_nsec <= nxt.a_nsec;
                    b_sec <= nxt.b_sec;
                    b_nsec <= nxt.b_nsec;
                end
                else
                begin
                    // junk on the data lines while idle
                    command <= cmd_t'($urandom_range(0, 3));
                    a_sec <= $urandom;
                    a_nsec <= $urandom;
                    b_sec <= $urandom;
                    b_nsec <= $urandom;
                end
                start <= next_start;
                if (!next_start && command_words.size() == 0)
                    all_sent <= 1'b1;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        res_t exp_r;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result word with no prediction pending");
                error_count++;
            end
            else
            begin
                exp_r = predicted_results.pop_front();
                if (res_sec !== exp_r.sec)
                begin
                    $error("res_sec expected %0h got %0h", exp_r.sec, res_sec);
                    error_count++;
                end
                if (res_nsec !== exp_r.nsec)
                begin
                    $error("res_nsec expected %0h got %0h", exp_r.nsec, res_nsec);
                    error_count++;
                end
                if (is_equal !== exp_r.is_equal)
                begin
                    $error("is_equal expected %0b got %0b", exp_r.is_equal, is_equal);
                    error_count++;
                end
                if (is_greater !== exp_r.is_greater)
                begin
                    $error("is_greater expected %0b got %0b", exp_r.is_greater, is_greater);
                    error_count++;
                end
                if (is_less !== exp_r.is_less)
                begin
                    $error("is_less expected %0b got %0b", exp_r.is_less, is_less);
                    error_count++;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin : run_test
        logic [31:0] as;
        logic [31:0] an;
        cmd_t        c;

        // normalize: in range, boundary, several carries, saturation
        queue_word(CMD_NORM, 32'd5, 32'd0, 32'd5, 32'd0);
        queue_word(CMD_NORM, 32'd5, NSEC_LAST, 32'd4, 32'd7);
        queue_word(CMD_NORM, 32'd5, NS_PER_SEC, 32'd6, 32'd0);
        queue_word(CMD_NORM, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1);
        queue_word(CMD_NORM, SEC_MAX, NS_PER_SEC, SEC_MAX, NS_PER_SEC);
        queue_word(CMD_NORM, SEC_MAX - 32'd2, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_word(CMD_NORM, SEC_MAX, 32'd5, 32'd0, 32'hFFFF_FFFF);
        // add: seconds overflow, carry at the top, plain carry, wrap, late normalize
        queue_word(CMD_ADD, SEC_MAX, 32'd0, 32'd1, 32'd0);
        queue_word(CMD_ADD, SEC_MAX - 32'd1, 32'd600000000, 32'd1, 32'd600000000);
        queue_word(CMD_ADD, 32'd10, 32'd600000000, 32'd20, 32'd600000000);
        queue_word(CMD_ADD, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd2);
        queue_word(CMD_ADD, 32'd3, 32'd4000000000, 32'd4, 32'd0);
        queue_word(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
        // subtract: underrun, nanosecond underrun, borrow, wrapping borrow, plain
        queue_word(CMD_SUB, 32'd3, 32'd0, 32'd4, 32'd0);
        queue_word(CMD_SUB, 32'd7, 32'd1, 32'd7, 32'd2);
        queue_word(CMD_SUB, 32'd9, 32'd100, 32'd7, 32'd200);
        queue_word(CMD_SUB, SEC_MAX, 32'd0, 32'd0, 32'hFFFF_FFFF);
        queue_word(CMD_SUB, SEC_MAX, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_word(CMD_SUB, 32'd7, 32'd5, 32'd7, 32'd5);
        // compare only: equal, greater, less, extremes
        queue_word(CMD_CMP, 32'd4, 32'd9, 32'd4, 32'd9);
        queue_word(CMD_CMP, 32'd4, 32'd10, 32'd4, 32'd9);
        queue_word(CMD_CMP, 32'd3, 32'hFFFF_FFFF, 32'd4, 32'd0);
        queue_word(CMD_CMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(CMD_CMP, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // random words, often with shared parts to hit the equal paths
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            c = cmd_t'($urandom_range(0, 3));
            as = pick_sec();
            an = pick_nsec();
            queue_word(c, as, an,
                       ($urandom_range(0, 3) == 0) ? as : pick_sec(),
                       ($urandom_range(0, 4) == 0) ? an : pick_nsec());
        end
        total_words = command_words.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (!all_sent) @(posedge clk);
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
